// ===== rtl/core/ctlv_pkg.sv =====
// Shared types and constants for the comprehension-TLV header parser.
`default_nettype none

package ctlv_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int OFFSET_W          = 16;
  localparam int LENGTH_W          = 24;
  localparam int TAG_W             = 15;

  localparam logic [7:0]  TAG_EXT_BYTE  = 8'h7f;
  localparam logic [7:0]  TAG_BAD_ZERO  = 8'h00;
  localparam logic [7:0]  TAG_BAD_HALF  = 8'h80;
  localparam logic [7:0]  TAG_BAD_ONES  = 8'hff;
  localparam logic [7:0]  LEN_LONG_MARK = 8'h80;
  localparam logic [7:0]  LEN_FORM_ONE  = 8'h81;
  localparam logic [7:0]  LEN_FORM_TWO  = 8'h82;
  localparam logic [7:0]  LEN_FORM_THREE = 8'h83;
  localparam logic [23:0] LEN_MIN_ONE   = 24'h000080;
  localparam logic [23:0] LEN_MIN_TWO   = 24'h000100;
  localparam logic [23:0] LEN_MIN_THREE = 24'h010000;
  localparam logic [15:0] TAG_CR_MASK   = 16'h8000;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_TAG,
    PH_TAGHI,
    PH_TAGLO,
    PH_LEN,
    PH_LENX,
    PH_VALUE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_BAD_TAG   = 3'd1,
    KIND_BAD_LEN   = 3'd2,
    KIND_TRUNCATED = 3'd3,
    KIND_END       = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [TAG_W-1:0]    tag_value;
    logic                comprehension_required;
    logic [LENGTH_W-1:0] value_length;
    logic [OFFSET_W-1:0] value_offset;
    logic                buffer_end;
  } result_item_t;

  // Held byte request between the input register and the decoder.
  typedef struct packed {
    logic       valid;
    byte_item_t item;
  } byte_req_t;

  // Result request between the decoder and the output register.
  typedef struct packed {
    logic         valid;
    result_item_t item;
  } result_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/ctlv_chan_if.sv =====
// Valid/ready channel interface with a typed payload.
`default_nettype none

interface ctlv_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/comprehension_tlv_header_parser.sv =====
// Top level of the comprehension-TLV header parser.
//
// byte_stream carries one buffer byte per request with last_byte marking the
// final byte. result_stream carries one result per complete TLV header, per
// error and per buffer end (buffer_end = 1); a header or error on the final
// byte is that end result. cfg writes start_offset, the bytes skipped at the
// head of each buffer; write it only while no bytes are in flight. cfg is always ready.
//
// Throughput is one byte per cycle while the receiver takes results: a byte
// waits in the input register, is decoded combinationally against the parser
// state and its result, if any, lands in the result register. When the
// receiver stalls, the result register holds and the input register fills;
// byte_stream.ready drops only when both are occupied and the result is not
// taken.
//
// Reset clears the parser state, start_offset and both registers. After a
// byte with last_byte set the parser returns to its start-of-buffer state.
// Byte positions saturate at 2^POSITION_BITS - 1.
`default_nettype none

module comprehension_tlv_header_parser #(
  parameter int POSITION_BITS = ctlv_pkg::POSITION_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  ctlv_chan_if.sink    byte_stream,
  ctlv_chan_if.source  result_stream,
  ctlv_chan_if.sink    cfg
);

  logic                  advance;
  ctlv_pkg::byte_req_t   held;
  ctlv_pkg::result_req_t res;

  assign cfg.ready = 1'b1;

  ctlv_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_stream.valid),
    .in_item  (byte_stream.payload),
    .in_ready (byte_stream.ready),
    .advance  (advance),
    .held     (held)
  );

  ctlv_decoder #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dec (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.payload),
    .held     (held),
    .advance  (advance),
    .res      (res)
  );

  ctlv_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .advance   (advance),
    .out_valid (result_stream.valid),
    .out_item  (result_stream.payload),
    .out_ready (result_stream.ready)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ctlv_in_stage.sv =====
// Input register: holds one accepted byte until the decoder consumes it.
`default_nettype none

module ctlv_in_stage (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  input  ctlv_pkg::byte_item_t   in_item,
  output logic                   in_ready,
  input  wire                    advance,
  output ctlv_pkg::byte_req_t    held
);

  logic                 valid_q;
  ctlv_pkg::byte_item_t item_q;

  assign in_ready   = !valid_q || advance;
  assign held.valid = valid_q;
  assign held.item  = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ctlv_decoder.sv =====
// Parser state and per-byte decode of the TLV header chain.
`default_nettype none

module ctlv_decoder #(
  parameter int POSITION_BITS = ctlv_pkg::POSITION_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [ctlv_pkg::OFFSET_W-1:0]       cfg_data,
  input  ctlv_pkg::byte_req_t                held,
  input  wire                                advance,
  output ctlv_pkg::result_req_t              res
);

  localparam int OW = ctlv_pkg::OFFSET_W;
  localparam int LW = ctlv_pkg::LENGTH_W;

  logic [OW-1:0]            start_offset;
  ctlv_pkg::phase_t         phase, phase_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [15:0]              tag_acc, tag_acc_next;
  logic [LW-1:0]            len_acc, len_acc_next;
  logic [1:0]               len_left, len_left_next;
  logic [1:0]               len_form, len_form_next;
  logic [LW-1:0]            skip_left, skip_left_next;
  logic                     stopped, stopped_next;

  logic                     step;
  ctlv_pkg::phase_t         ph;
  logic                     done_header;
  logic                     has_kind;
  ctlv_pkg::kind_t          kind_code;
  logic [7:0]               b;
  logic                     last;
  logic [LW-1:0]            len_shift;
  logic [1:0]               left_dec;
  logic [LW-1:0]            skip_dec;
  logic [LW-1:0]            len_min;
  logic [POSITION_BITS+OW-1:0] pos_ext;
  logic [POSITION_BITS+OW-1:0] start_ext;
  logic [POSITION_BITS+OW-1:0] voff_ext;

  assign step      = held.valid && advance;
  assign b         = held.item.data_byte;
  assign last      = held.item.last_byte;
  assign pos_ext   = {{OW{1'b0}}, byte_position};
  assign start_ext = {{POSITION_BITS{1'b0}}, start_offset};
  assign len_shift = {len_acc[LW-9:0], b};
  assign left_dec  = (len_left != 2'd0) ? len_left - 2'd1 : len_left;
  assign skip_dec  = (skip_left != '0) ? skip_left - 1'b1 : skip_left;

  always_comb begin
    unique case (len_form)
      2'd1:    len_min = ctlv_pkg::LEN_MIN_ONE;
      2'd2:    len_min = ctlv_pkg::LEN_MIN_TWO;
      default: len_min = ctlv_pkg::LEN_MIN_THREE;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    tag_acc_next       = tag_acc;
    len_acc_next       = len_acc;
    len_left_next      = len_left;
    len_form_next      = len_form;
    skip_left_next     = skip_left;
    stopped_next       = stopped;
    byte_position_next = (byte_position != '1) ? byte_position + 1'b1 : byte_position;
    voff_ext           = {{OW{1'b0}}, byte_position_next};
    done_header        = 1'b0;
    has_kind           = 1'b0;
    kind_code          = ctlv_pkg::KIND_END;
    ph                 = phase;
    res.item           = '0;

    if (!stopped) begin
      if (phase == ctlv_pkg::PH_SKIP && pos_ext >= start_ext) begin
        ph = ctlv_pkg::PH_TAG;
      end
      phase_next = ph;
      unique case (ph)
        ctlv_pkg::PH_TAG: begin
          if (b == ctlv_pkg::TAG_BAD_ZERO || b == ctlv_pkg::TAG_BAD_HALF ||
              b == ctlv_pkg::TAG_BAD_ONES) begin
            has_kind     = 1'b1;
            kind_code    = ctlv_pkg::KIND_BAD_TAG;
            stopped_next = 1'b1;
          end else if (b == ctlv_pkg::TAG_EXT_BYTE) begin
            phase_next = ctlv_pkg::PH_TAGHI;
          end else begin
            tag_acc_next = {b[7], 8'h00, b[6:0]};
            phase_next   = ctlv_pkg::PH_LEN;
          end
        end
        ctlv_pkg::PH_TAGHI: begin
          tag_acc_next = {b, 8'h00};
          phase_next   = ctlv_pkg::PH_TAGLO;
        end
        ctlv_pkg::PH_TAGLO: begin
          tag_acc_next = {tag_acc[15:8], tag_acc[7:0] | b};
          phase_next   = ctlv_pkg::PH_LEN;
        end
        ctlv_pkg::PH_LEN: begin
          if (b < ctlv_pkg::LEN_LONG_MARK) begin
            len_acc_next = {{(LW-8){1'b0}}, b};
            done_header  = 1'b1;
          end else if (b == ctlv_pkg::LEN_FORM_ONE || b == ctlv_pkg::LEN_FORM_TWO ||
                       b == ctlv_pkg::LEN_FORM_THREE) begin
            len_form_next = b[1:0];
            len_left_next = b[1:0];
            len_acc_next  = '0;
            phase_next    = ctlv_pkg::PH_LENX;
          end else begin
            has_kind     = 1'b1;
            kind_code    = ctlv_pkg::KIND_BAD_LEN;
            stopped_next = 1'b1;
          end
        end
        ctlv_pkg::PH_LENX: begin
          len_acc_next  = len_shift;
          len_left_next = left_dec;
          if (left_dec == 2'd0) begin
            // reject a length that fits a shorter form
            if (len_shift < len_min) begin
              has_kind     = 1'b1;
              kind_code    = ctlv_pkg::KIND_BAD_LEN;
              stopped_next = 1'b1;
            end else begin
              done_header = 1'b1;
            end
          end
        end
        ctlv_pkg::PH_VALUE: begin
          skip_left_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next = ctlv_pkg::PH_TAG;
          end
        end
        default: begin
        end
      endcase

      if (done_header) begin
        has_kind                        = 1'b1;
        kind_code                       = ctlv_pkg::KIND_HEADER;
        res.item.tag_value              = tag_acc[14:0];
        res.item.comprehension_required = tag_acc[15];
        res.item.value_length           = len_acc_next;
        res.item.value_offset           = voff_ext[OW-1:0];
        skip_left_next                  = len_acc_next;
        phase_next = (len_acc_next != '0) ? ctlv_pkg::PH_VALUE : ctlv_pkg::PH_TAG;
      end
    end

    if (last && !has_kind) begin
      has_kind = 1'b1;
      if (!stopped && (phase_next == ctlv_pkg::PH_TAGHI || phase_next == ctlv_pkg::PH_TAGLO ||
                       phase_next == ctlv_pkg::PH_LEN || phase_next == ctlv_pkg::PH_LENX)) begin
        kind_code = ctlv_pkg::KIND_TRUNCATED;
      end else begin
        kind_code = ctlv_pkg::KIND_END;
      end
    end

    res.item.kind       = kind_code;
    res.item.buffer_end = last;
    res.valid           = step && has_kind;

    // close the buffer: back to the start-of-buffer state
    if (last) begin
      phase_next         = ctlv_pkg::PH_SKIP;
      byte_position_next = '0;
      tag_acc_next       = '0;
      len_acc_next       = '0;
      len_left_next      = '0;
      len_form_next      = '0;
      skip_left_next     = '0;
      stopped_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= '0;
    end else if (cfg_we) begin
      start_offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ctlv_pkg::PH_SKIP;
      byte_position <= '0;
      tag_acc       <= '0;
      len_acc       <= '0;
      len_left      <= '0;
      len_form      <= '0;
      skip_left     <= '0;
      stopped       <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      tag_acc       <= tag_acc_next;
      len_acc       <= len_acc_next;
      len_left      <= len_left_next;
      len_form      <= len_form_next;
      skip_left     <= skip_left_next;
      stopped       <= stopped_next;
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    step && last |-> res.valid && res.item.buffer_end)
    else $error("closing byte produced no result");

  a_last_clears_position: assert property (@(posedge clk) disable iff (rst)
    step && last |=> byte_position == '0 && !stopped && phase == ctlv_pkg::PH_SKIP)
    else $error("parser not cleared after buffer end");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.item.kind != ctlv_pkg::KIND_HEADER |->
      res.item.value_length == '0 && res.item.value_offset == '0 &&
      res.item.tag_value == '0 && !res.item.comprehension_required)
    else $error("non-header result carries header fields");

  a_lenx_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == ctlv_pkg::PH_LENX && !stopped |-> len_left != 2'd0)
    else $error("long length form with no bytes left");

  a_value_has_skip: assert property (@(posedge clk) disable iff (rst)
    phase == ctlv_pkg::PH_VALUE && !stopped |-> skip_left != '0)
    else $error("value skip entered with zero count");

endmodule

`default_nettype wire

// ===== rtl/core/ctlv_out_stage.sv =====
// Result register: holds one result until the receiver takes it.
`default_nettype none

module ctlv_out_stage (
  input  wire                     clk,
  input  wire                     rst,
  input  ctlv_pkg::result_req_t   res,
  output logic                    advance,
  output logic                    out_valid,
  output ctlv_pkg::result_item_t  out_item,
  input  wire                     out_ready
);

  // advance when the register is empty or its result is taken this cycle
  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_item <= res.item;
    end
  end

endmodule

`default_nettype wire
